// ===== rtl/core/btg_pkg.sv =====
// Shared widths, constants and control structs for the buzzer tone generator.
package btg_pkg;

  localparam int CLK_W = 24;           // tick rate register
  localparam int HZ_W  = 16;           // note frequency
  localparam int DUR_W = 16;           // note duration
  localparam int CNT_W = 32;           // periods left
  localparam int MS_W  = 10;           // bits of the ms-per-second constant

  // shared divider: dividend holds clock*duration, divisor holds period*1000
  localparam int DIV_DW = CLK_W + DUR_W;
  localparam int DIV_VW = CLK_W + MS_W;

  localparam logic [CLK_W-1:0] CLOCK_RESET = 24'd1200000;
  localparam logic [MS_W-1:0]  MS_PER_S    = 10'd1000;
  localparam logic [CLK_W-1:0] MIN_PERIOD  = 24'd2;

  typedef struct packed {
    logic             tick;
    logic             load;
    logic [CLK_W-1:0] period;
    logic [CNT_W-1:0] count;
    logic             sound;
  } tone_cmd_t;

  typedef struct packed {
    logic pin;
    logic busy;
    logic done;
  } tone_res_t;

endpackage

// ===== rtl/core/btg_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
module btg_div #(
  parameter int DW = btg_pkg::DIV_DW,
  parameter int VW = btg_pkg::DIV_VW
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = (DW > 1) ? $clog2(DW) : 1;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [VW-1:0] dvs_r, dvs_nxt;
  logic [VW:0]   trial;
  logic [VW:0]   diff;

  assign trial = {rem_r, quo_r[DW-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[VW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[VW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/core/btg_tone.sv =====
// Tone state: period counter, periods left and pin level.
module btg_tone (
  input  logic                clk,
  input  logic                rst_n,
  input  btg_pkg::tone_cmd_t  cmd,
  output btg_pkg::tone_res_t  res,
  output logic                playing
);

  logic [btg_pkg::CLK_W-1:0] period_r, period_nxt;
  logic [btg_pkg::CLK_W-1:0] tick_r, tick_nxt;
  logic [btg_pkg::CNT_W-1:0] left_r, left_nxt;
  logic                      snd_r, snd_nxt;
  logic                      play_r, play_nxt;
  logic                      done;

  always_comb begin
    period_nxt = period_r;
    tick_nxt   = tick_r;
    left_nxt   = left_r;
    snd_nxt    = snd_r;
    play_nxt   = play_r;
    done       = 1'b0;
    if (cmd.load) begin
      period_nxt = cmd.period;
      tick_nxt   = '0;
      left_nxt   = cmd.count;
      snd_nxt    = cmd.sound;
      play_nxt   = 1'b1;
    end else if (cmd.tick && play_r) begin
      if (tick_r >= period_r) begin
        tick_nxt = '0;
        if (left_r != '0) begin
          left_nxt = left_r - 1'b1;
        end
        // last period wraps: note over
        if (left_r <= btg_pkg::CNT_W'(1)) begin
          play_nxt = 1'b0;
          snd_nxt  = 1'b0;
          done     = 1'b1;
        end
      end else begin
        tick_nxt = tick_r + 1'b1;
      end
    end
  end

  assign res.pin  = play_nxt && snd_nxt && (tick_nxt < (period_nxt >> 1));
  assign res.busy = play_nxt;
  assign res.done = done;
  assign playing  = play_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= '0;
      tick_r   <= '0;
      left_r   <= '0;
      snd_r    <= 1'b0;
      play_r   <= 1'b0;
    end else begin
      period_r <= period_nxt;
      tick_r   <= tick_nxt;
      left_r   <= left_nxt;
      snd_r    <= snd_nxt;
      play_r   <= play_nxt;
    end
  end

endmodule

// ===== rtl/core/buzzer_tone_generator.sv =====
// Buzzer tone generator top level: request sequencer, divider and tone counter.
//
// Input channel (in_*): each transfer is one request. in_tuser = 0 starts a
// note (in_tdata = note_hz, duration_ms), in_tuser = 1 is one elapsed tick.
// Output channel (out_*): exactly one result transfer per request, carrying
// the pin level and busy flag in out_tdata; out_tlast marks the tick that
// ends the last period of a note.
// Config: cfg_we writes cfg_wdata into the tick rate (clock_hz) register.
//
// A tick, a start while a note plays, or a tick while idle is handled in the
// cycle it is accepted; its result is registered and shows the next cycle,
// and a new request can be taken every cycle as long as out_tready keeps up.
// A start while idle runs the shared restoring divider (one bit per cycle,
// 40 steps a pass): clock/note, two product regs, then
// clock*duration/(1000*period); a rest (zero note) takes one divider
// pass. in_tready is low until the sequencer returns to idle.
// While out_tready is low and a result is held, no new request is taken.
// Reset: idle, pin low, clock_hz = 1200000, no result pending.
module buzzer_tone_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] note_hz, [31:16] duration_ms
  input  logic        in_tuser,   // [0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] pin_level, [1] busy_res, [7:2] zero
  output logic        out_tlast,  // note_done
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata   // clock_hz
);

  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE  = 3'd0;
  localparam logic [ST_W-1:0] ST_DIV1  = 3'd1;
  localparam logic [ST_W-1:0] ST_MUL   = 3'd2;
  localparam logic [ST_W-1:0] ST_DIV2S = 3'd3;
  localparam logic [ST_W-1:0] ST_DIV2  = 3'd4;
  localparam logic [ST_W-1:0] ST_LOAD  = 3'd5;

  localparam int DW = btg_pkg::DIV_DW;
  localparam int VW = btg_pkg::DIV_VW;

  logic [ST_W-1:0]            st_r, st_nxt;
  logic [btg_pkg::CLK_W-1:0]  clock_r;
  logic [btg_pkg::HZ_W-1:0]   note_r, note_nxt;
  logic [btg_pkg::DUR_W-1:0]  dur_r, dur_nxt;
  logic [btg_pkg::CLK_W-1:0]  period_r, period_nxt;
  logic [btg_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [DW-1:0]              prod_r, prod_nxt;
  logic [VW-1:0]              divs_r, divs_nxt;
  logic                       out_valid_r, out_valid_nxt;
  btg_pkg::tone_res_t         out_res_r, out_res_nxt;

  logic                       out_free;
  logic                       in_xfer;
  logic                       div_start;
  logic [DW-1:0]              div_dividend;
  logic [VW-1:0]              div_divisor;
  logic                       div_done;
  logic [DW-1:0]              div_quo;
  logic [btg_pkg::CLK_W-1:0]  quo_period;
  logic [btg_pkg::CNT_W-1:0]  quo_count;
  btg_pkg::tone_cmd_t         cmd;
  btg_pkg::tone_res_t         res;
  logic                       playing;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (st_r == ST_IDLE) && out_free;
  assign in_xfer   = in_tvalid && in_tready;

  // divider operands: first pass at accept of a start, second from products
  assign div_dividend = (st_r == ST_IDLE) ? DW'(clock_r) : prod_r;
  assign div_divisor  = (st_r == ST_IDLE) ?
                        ((in_tdata[15:0] == '0) ? VW'(btg_pkg::MS_PER_S)
                                                : VW'(in_tdata[15:0])) : divs_r;

  // clock/note never exceeds clock; period below two is raised to two
  assign quo_period = (div_quo[btg_pkg::CLK_W-1:1] == '0) ? btg_pkg::MIN_PERIOD
                                                          : div_quo[btg_pkg::CLK_W-1:0];
  assign quo_count  = (div_quo[btg_pkg::CNT_W-1:0] == '0) ? btg_pkg::CNT_W'(1)
                                                          : div_quo[btg_pkg::CNT_W-1:0];

  always_comb begin
    st_nxt        = st_r;
    note_nxt      = note_r;
    dur_nxt       = dur_r;
    period_nxt    = period_r;
    count_nxt     = count_r;
    prod_nxt      = prod_r;
    divs_nxt      = divs_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_res_nxt   = out_res_r;
    div_start     = 1'b0;
    cmd.tick      = 1'b0;
    cmd.load      = 1'b0;
    cmd.period    = period_r;
    cmd.count     = count_r;
    cmd.sound     = (note_r != '0) && (dur_r != '0);

    unique case (st_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_tuser || playing) begin
            // tick, or start ignored while busy: result now
            cmd.tick      = in_tuser;
            out_valid_nxt = 1'b1;
            out_res_nxt   = res;
          end else begin
            note_nxt  = in_tdata[15:0];
            dur_nxt   = in_tdata[31:16];
            div_start = 1'b1;
            st_nxt    = ST_DIV1;
          end
        end
      end
      ST_DIV1: begin
        if (div_done) begin
          period_nxt = quo_period;
          if (note_r == '0) begin
            count_nxt = (dur_r == '0) ? btg_pkg::CNT_W'(1) : btg_pkg::CNT_W'(dur_r);
            st_nxt    = ST_LOAD;
          end else begin
            st_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        prod_nxt = DW'(clock_r) * DW'(dur_r);
        divs_nxt = VW'(period_r) * VW'(btg_pkg::MS_PER_S);
        st_nxt   = ST_DIV2S;
      end
      ST_DIV2S: begin
        div_start = 1'b1;
        st_nxt    = ST_DIV2;
      end
      ST_DIV2: begin
        if (div_done) begin
          count_nxt = quo_count;
          st_nxt    = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (out_free) begin
          cmd.load      = 1'b1;
          out_valid_nxt = 1'b1;
          out_res_nxt   = res;
          st_nxt        = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  btg_div #(
    .DW(DW),
    .VW(VW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  btg_tone u_tone (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .res     (res),
    .playing (playing)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      clock_r     <= btg_pkg::CLOCK_RESET;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        clock_r <= cfg_wdata;
      end
    end
    note_r    <= note_nxt;
    dur_r     <= dur_nxt;
    period_r  <= period_nxt;
    count_r   <= count_nxt;
    prod_r    <= prod_nxt;
    divs_r    <= divs_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_res_r.busy, out_res_r.pin};
  assign out_tlast  = out_res_r.done;

  // divider only finishes while the sequencer waits on it
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (st_r == ST_DIV1 || st_r == ST_DIV2))
    else $error("divider done outside a divide state");

  // a start taken while idle launches the divider
  a_start_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !in_tuser && !playing) |=> (st_r == ST_DIV1))
    else $error("start did not enter first divide");

  // loading a note gives a busy result and returns to idle
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_LOAD && out_free) |=> (st_r == ST_IDLE && out_valid_r && out_tdata[1]))
    else $error("note load did not produce busy result");

  // end of note result is never busy
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tlast) |-> !out_tdata[1])
    else $error("note_done with busy set");

endmodule
